// ===== sv/h2r_pkg.sv =====
// h2r_pkg: shared types and constants for the hsv to rgb converter
// field widths of the pixel beats, sector codes and pipeline depth
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

    localparam int HUE_W  = 16;
    localparam int SV_W   = 12;
    localparam int OUT_W  = 11;
    localparam int SEC_W  = 3;

    // defaults for the top level parameters
    localparam int DEF_FRAC_BITS     = 10;
    localparam int DEF_HUE_FRAC_BITS = 4;

    // register stages from input beat to output register
    localparam int PIPE_DEPTH = 8;

    // 60 degree hue sectors
    typedef enum logic [SEC_W-1:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic signed [SV_W-1:0]  saturation;
        logic signed [SV_W-1:0]  brightness;
    } hsv_pix_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_pix_t;

endpackage

`default_nettype wire

// ===== sv/h2r_hue.sv =====
// h2r_hue: hue datapath, wraps the angle into one turn and splits it into
// a sector code and a fraction within the sector, five register stages
// depends on h2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module h2r_hue
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int HUE_FRAC_BITS = DEF_HUE_FRAC_BITS
)
(
    input  wire logic                    clk,
    input  wire logic [PIPE_DEPTH-1:0]   en,
    input  wire logic signed [HUE_W-1:0] hue,
    output sector_t                      sector,
    output logic [FRAC_BITS-1:0]         frac
);

    localparam int TURN     = 360 << HUE_FRAC_BITS;
    localparam int SECTOR   = 60 << HUE_FRAC_BITS;
    localparam int W_W      = $clog2((1 << HUE_W) + TURN);
    localparam int WRAP_OFF = (TURN - ((1 << (HUE_W - 1)) % TURN)) % TURN;
    // turn = 45 << SH_T, so the turn count is a divide by 45
    localparam int SH_T     = HUE_FRAC_BITS + 3;
    localparam int WT_W     = W_W - SH_T;
    localparam int LT       = WT_W + 6;
    localparam longint RT   = ((longint'(1) << LT) + 44) / 45;
    localparam int RT_W     = WT_W + 1;
    localparam int QT_W     = WT_W - 5;
    localparam int HW_W     = $clog2(TURN);
    localparam int REM_W    = $clog2(SECTOR);
    // fraction = rem * one / sector = (rem * one >> (hfb + 2)) / 15
    localparam int SH_X     = HUE_FRAC_BITS + 2;
    localparam int RS_W     = REM_W + FRAC_BITS;
    localparam int X_W      = FRAC_BITS + 4;
    localparam int LX       = X_W + 4;
    localparam longint RX   = ((longint'(1) << LX) + 14) / 15;
    localparam int RX_W     = X_W + 1;

    logic [HUE_W-1:0]     hue_u;
    logic [W_W-1:0]       w_next;
    logic [W_W-1:0]       w_reg;
    logic [W_W-1:0]       w1_reg;
    logic [WT_W+RT_W-1:0] turn_prod;
    logic [QT_W-1:0]      qt_next;
    logic [QT_W-1:0]      qt_reg;
    logic [HW_W-1:0]      hw_next;
    logic [HW_W-1:0]      hw_reg;
    sector_t              sec_next;
    sector_t              sec3_reg;
    sector_t              sec4_reg;
    logic [HW_W-1:0]      sec_base;
    logic [REM_W-1:0]     rem;
    logic [RS_W-1:0]      rem_sh;
    logic [X_W-1:0]       x_next;
    logic [X_W-1:0]       x_reg;
    logic [X_W+RX_W-1:0]  frac_prod;
    logic [FRAC_BITS-1:0] frac_next;
    logic [FRAC_BITS-1:0] frac_reg;

    // offset binary plus a whole number of turns keeps the value positive
    assign hue_u  = {~hue[HUE_W-1], hue[HUE_W-2:0]};
    assign w_next = W_W'(hue_u) + W_W'(WRAP_OFF);

    assign turn_prod = w_reg[W_W-1:SH_T] * RT_W'(RT);
    assign qt_next   = QT_W'(turn_prod >> LT);

    assign hw_next = HW_W'(w1_reg - W_W'(qt_reg * TURN));

    always_comb
    begin
        sec_next = SEC_RED_YEL;
        sec_base = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (32'(hw_reg) >= k * SECTOR)
            begin
                sec_next = sector_t'(SEC_W'(k));
                sec_base = HW_W'(k * SECTOR);
            end
        end
    end

    assign rem    = REM_W'(hw_reg - sec_base);
    assign rem_sh = {rem, {FRAC_BITS{1'b0}}} >> SH_X;
    assign x_next = rem_sh[X_W-1:0];

    assign frac_prod = x_reg * RX_W'(RX);
    assign frac_next = FRAC_BITS'(frac_prod >> LX);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg <= w_next;
        end
        if (en[1])
        begin
            w1_reg <= w_reg;
            qt_reg <= qt_next;
        end
        if (en[2])
        begin
            hw_reg <= hw_next;
        end
        if (en[3])
        begin
            sec3_reg <= sec_next;
            x_reg    <= x_next;
        end
        if (en[4])
        begin
            sec4_reg <= sec3_reg;
            frac_reg <= frac_next;
        end
    end

    assign sector = sec4_reg;
    assign frac   = frac_reg;

endmodule

`default_nettype wire

// ===== sv/h2r_shade.sv =====
// h2r_shade: clamps saturation and value and forms p, q and t with
// truncating fixed point products, seven register stages
// depends on h2r_pkg; takes the hue fraction from h2r_hue
`timescale 1ns / 1ps
`default_nettype none

module h2r_shade
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic [PIPE_DEPTH-1:0]  en,
    input  wire logic signed [SV_W-1:0] saturation,
    input  wire logic signed [SV_W-1:0] brightness,
    input  wire logic [FRAC_BITS-1:0]   frac,
    output logic                        gray,
    output logic [FRAC_BITS:0]          vval,
    output logic [FRAC_BITS:0]          pval,
    output logic [FRAC_BITS:0]          qval,
    output logic [FRAC_BITS:0]          tval
);

    localparam int S_W   = FRAC_BITS + 1;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int CMP_W = (S_W > SV_W - 1) ? S_W : SV_W - 1;

    logic [S_W-1:0]   s_next;
    logic [S_W-1:0]   v_next;
    logic [S_W-1:0]   s_reg [0:4];
    logic [S_W-1:0]   v_reg [0:6];
    logic             z_reg [0:6];
    logic [S_W-1:0]   one_minus_s;
    logic [2*S_W-1:0] p_prod;
    logic [S_W-1:0]   p_next;
    logic [S_W-1:0]   p4_reg;
    logic [S_W-1:0]   p5_reg;
    logic [S_W-1:0]   p6_reg;
    logic [S_W-1:0]   one_minus_f;
    logic [2*S_W-1:0] sf_prod;
    logic [2*S_W-1:0] sf1_prod;
    logic [S_W-1:0]   sf_reg;
    logic [S_W-1:0]   sf1_reg;
    logic [2*S_W-1:0] q_prod;
    logic [2*S_W-1:0] t_prod;
    logic [S_W-1:0]   q_reg;
    logic [S_W-1:0]   t_reg;

    always_comb
    begin
        if (saturation[SV_W-1])
            s_next = '0;
        else if (CMP_W'(saturation[SV_W-2:0]) > CMP_W'(ONE))
            s_next = S_W'(ONE);
        else
            s_next = S_W'(saturation[SV_W-2:0]);

        if (brightness[SV_W-1])
            v_next = '0;
        else if (CMP_W'(brightness[SV_W-2:0]) > CMP_W'(ONE))
            v_next = S_W'(ONE);
        else
            v_next = S_W'(brightness[SV_W-2:0]);
    end

    assign one_minus_s = S_W'(ONE) - s_reg[3];
    assign p_prod      = v_reg[3] * one_minus_s;
    assign p_next      = S_W'(p_prod >> FRAC_BITS);

    // fraction lines up with stage four
    assign one_minus_f = S_W'(ONE) - S_W'(frac);
    assign sf_prod     = s_reg[4] * S_W'(frac);
    assign sf1_prod    = s_reg[4] * one_minus_f;

    assign q_prod = v_reg[5] * (S_W'(ONE) - sf_reg);
    assign t_prod = v_reg[5] * (S_W'(ONE) - sf1_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg[0] <= s_next;
            v_reg[0] <= v_next;
            z_reg[0] <= (s_next == '0);
        end
        for (int k = 1; k < 5; k++)
        begin
            if (en[k])
                s_reg[k] <= s_reg[k-1];
        end
        for (int k = 1; k < 7; k++)
        begin
            if (en[k])
            begin
                v_reg[k] <= v_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
        end
        if (en[4])
            p4_reg <= p_next;
        if (en[5])
        begin
            p5_reg  <= p4_reg;
            sf_reg  <= S_W'(sf_prod >> FRAC_BITS);
            sf1_reg <= S_W'(sf1_prod >> FRAC_BITS);
        end
        if (en[6])
        begin
            p6_reg <= p5_reg;
            q_reg  <= S_W'(q_prod >> FRAC_BITS);
            t_reg  <= S_W'(t_prod >> FRAC_BITS);
        end
    end

    assign gray = z_reg[6];
    assign vval = v_reg[6];
    assign pval = p6_reg;
    assign qval = q_reg;
    assign tval = t_reg;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter_top.sv =====
// hsv_to_rgb_converter_top: pipelined hsv to rgb pixel converter
// depends on h2r_pkg, h2r_hue and h2r_shade
// Takes one pixel per clock while hsv_stall is low and passes it through the
// pipeline stages in order: clamp and hue offset, turn count, hue wrap,
// sector split, sector fraction and p, s*f products, q and t products,
// channel select into the output register. Each stage holds a valid bit
// and moves whenever the stage after it is empty or moving, so bubbles
// close up and a stalled output register still lets upstream stages fill;
// hsv_stall rises only when every stage holds a beat and rgb_stall is high.
// No memories, nothing to clear after reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_top
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS     = DEF_FRAC_BITS,
    parameter int HUE_FRAC_BITS = DEF_HUE_FRAC_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     hsv_valid,
    output logic          hsv_stall,
    input  wire hsv_pix_t hsv,
    output logic          rgb_valid,
    input  wire logic     rgb_stall,
    output rgb_pix_t      rgb
);

    localparam int S_W = FRAC_BITS + 1;
    localparam int ONE = 1 << FRAC_BITS;

    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] valid_reg;
    sector_t               sector;
    logic [FRAC_BITS-1:0]  frac;
    sector_t               sec5_reg;
    sector_t               sec6_reg;
    logic                  gray;
    logic [S_W-1:0]        vval;
    logic [S_W-1:0]        pval;
    logic [S_W-1:0]        qval;
    logic [S_W-1:0]        tval;
    logic [S_W-1:0]        r_sel;
    logic [S_W-1:0]        g_sel;
    logic [S_W-1:0]        b_sel;
    rgb_pix_t              rgb_next;
    rgb_pix_t              rgb_reg;

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !rgb_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    always_comb
    begin
        valid_next    = valid_reg;
        if (en[0])
            valid_next[0] = hsv_valid;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (en[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    h2r_hue #(
        .FRAC_BITS     (FRAC_BITS),
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_hue (
        .clk    (clk),
        .en     (en),
        .hue    (hsv.hue),
        .sector (sector),
        .frac   (frac)
    );

    h2r_shade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_shade (
        .clk        (clk),
        .en         (en),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .frac       (frac),
        .gray       (gray),
        .vval       (vval),
        .pval       (pval),
        .qval       (qval),
        .tval       (tval)
    );

    always_comb
    begin
        case (sec6_reg)
            SEC_RED_YEL: begin r_sel = vval; g_sel = tval; b_sel = pval; end
            SEC_YEL_GRN: begin r_sel = qval; g_sel = vval; b_sel = pval; end
            SEC_GRN_CYN: begin r_sel = pval; g_sel = vval; b_sel = tval; end
            SEC_CYN_BLU: begin r_sel = pval; g_sel = qval; b_sel = vval; end
            SEC_BLU_MAG: begin r_sel = tval; g_sel = pval; b_sel = vval; end
            SEC_MAG_RED: begin r_sel = vval; g_sel = pval; b_sel = qval; end
            default:     begin r_sel = vval; g_sel = tval; b_sel = pval; end
        endcase
        if (gray)
        begin
            r_sel = vval;
            g_sel = vval;
            b_sel = vval;
        end
        rgb_next.red   = OUT_W'(r_sel);
        rgb_next.green = OUT_W'(g_sel);
        rgb_next.blue  = OUT_W'(b_sel);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            sec5_reg <= sector;
        if (en[6])
            sec6_reg <= sec5_reg;
        if (en[7])
            rgb_reg <= rgb_next;
    end

    assign hsv_stall = !en[0];
    assign rgb_valid = valid_reg[PIPE_DEPTH-1];
    assign rgb       = rgb_reg;

    // an empty entry stage never pushes back
    a_entry_free: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !hsv_stall)
        else $error("entry stage empty but input stalled");

    // beat count grows by one on input without output
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (hsv_valid && !hsv_stall && !(rgb_valid && !rgb_stall)) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("input beat lost in pipeline");

    // beat count shrinks by one on output without input
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && !rgb_stall && !(hsv_valid && !hsv_stall)) |=>
        ($countones(valid_reg) == $past($countones(valid_reg)) - 1))
        else $error("output beat repeated or invented");

    // channels never exceed full intensity, checked only for FRAC_BITS up to 10
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> ((FRAC_BITS > 10) || ((32'(rgb.red) <= ONE) &&
        (32'(rgb.green) <= ONE) && (32'(rgb.blue) <= ONE))))
        else $error("rgb channel above one");

endmodule

`default_nettype wire
